// ----- rtl/core/lvs_pkg.sv -----
package lvs_pkg;

  localparam int unsigned FrameW = 6;
  localparam int unsigned CountW = 7;

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CountW-1:0] count_t;

  localparam logic [1:0] CMD_VICTIM = 2'd0;
  localparam logic [1:0] CMD_PIN    = 2'd1;
  localparam logic [1:0] CMD_UNPIN  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    frame_t     frame_idx;
  } req_t;

  typedef struct packed {
    logic   found;
    frame_t victim_frame;
    count_t list_count;
  } resp_t;

  // one write into a link memory
  typedef struct packed {
    logic   we;
    frame_t addr;
    frame_t data;
  } link_wr_t;

endpackage

// ----- rtl/core/lvs_link_mem.sv -----
module lvs_link_mem #(
  parameter int unsigned IdxW     = 6,
  parameter int unsigned MemDepth = 64
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  lvs_pkg::frame_t   rd_addr_i,
  input  lvs_pkg::link_wr_t wr_i,
  output lvs_pkg::frame_t   rd_data_o
);

  lvs_pkg::frame_t mem [MemDepth];
  lvs_pkg::frame_t rd_q;
  lvs_pkg::frame_t byp_data_q;
  logic            byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr[IdxW-1:0]] <= wr_i.data;
    end
  end

  // read-during-write on the same entry returns the new link
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i[IdxW-1:0]];
      byp_q      <= wr_i.we && (wr_i.addr[IdxW-1:0] == rd_addr_i[IdxW-1:0]);
      byp_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

// ----- rtl/core/lvs_list_ctrl.sv -----
module lvs_list_ctrl #(
  parameter int unsigned NumFrames = 64,
  parameter int unsigned IdxW      = 6,
  parameter int unsigned MemDepth  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lvs_pkg::req_t     req_i,
  input  lvs_pkg::frame_t   nxt_rd_i,
  input  lvs_pkg::frame_t   prv_rd_i,
  output lvs_pkg::resp_t    resp_o,
  output lvs_pkg::frame_t   head_nxt_o,
  output lvs_pkg::link_wr_t nxt_wr_o,
  output lvs_pkg::link_wr_t prv_wr_o
);

  logic [MemDepth-1:0] in_list_q;
  lvs_pkg::frame_t     head_q, head_d;
  lvs_pkg::frame_t     tail_q, tail_d;
  lvs_pkg::count_t     cnt_q, cnt_d;

  logic              f_ok;
  logic              f_listed;
  logic              set_en, clr_en;
  lvs_pkg::frame_t   clr_frame;
  lvs_pkg::link_wr_t nxt_wr, prv_wr;

  assign f_ok     = int'(req_i.frame_idx) < NumFrames;
  assign f_listed = f_ok && in_list_q[req_i.frame_idx[IdxW-1:0]];

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    set_en    = 1'b0;
    clr_en    = 1'b0;
    clr_frame = req_i.frame_idx;
    nxt_wr    = '0;
    prv_wr    = '0;
    resp_o.found        = 1'b0;
    resp_o.victim_frame = '0;
    case (req_i.command)
      lvs_pkg::CMD_VICTIM: begin
        if (cnt_q != '0) begin
          resp_o.found        = 1'b1;
          resp_o.victim_frame = head_q;
          clr_en    = 1'b1;
          clr_frame = head_q;
          cnt_d     = cnt_q - 7'd1;
          if (cnt_q > 7'd1) begin
            head_d = nxt_rd_i;
          end
        end
      end
      lvs_pkg::CMD_PIN: begin
        if (f_listed) begin
          clr_en = 1'b1;
          cnt_d  = cnt_q - 7'd1;
          if (cnt_q > 7'd1) begin
            if (req_i.frame_idx == head_q) begin
              head_d = nxt_rd_i;
            end else if (req_i.frame_idx == tail_q) begin
              tail_d = prv_rd_i;
            end else begin
              // splice neighbors around the removed frame
              nxt_wr = '{we: 1'b1, addr: prv_rd_i, data: nxt_rd_i};
              prv_wr = '{we: 1'b1, addr: nxt_rd_i, data: prv_rd_i};
            end
          end
        end
      end
      lvs_pkg::CMD_UNPIN: begin
        if (f_ok && !f_listed) begin
          if (cnt_q == '0) begin
            head_d = req_i.frame_idx;
          end else begin
            nxt_wr = '{we: 1'b1, addr: tail_q, data: req_i.frame_idx};
            prv_wr = '{we: 1'b1, addr: req_i.frame_idx, data: tail_q};
          end
          tail_d = req_i.frame_idx;
          set_en = 1'b1;
          cnt_d  = cnt_q + 7'd1;
        end
      end
      default: begin
      end
    endcase
    resp_o.list_count = cnt_d;
  end

  assign nxt_wr_o   = '{we: nxt_wr.we & step_i, addr: nxt_wr.addr, data: nxt_wr.data};
  assign prv_wr_o   = '{we: prv_wr.we & step_i, addr: prv_wr.addr, data: prv_wr.data};
  assign head_nxt_o = step_i ? head_d : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_list_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      if (clr_en) begin
        in_list_q[clr_frame[IdxW-1:0]] <= 1'b0;
      end
      if (set_en) begin
        in_list_q[req_i.frame_idx[IdxW-1:0]] <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/lru_victim_selector.sv -----
// LRU victim selector: keeps the evictable frames in a doubly linked list, oldest
// first. Each request (take victim, pin, unpin) yields exactly one response with
// the list length after the request. One request is accepted every cycle while
// the output is not stalled; the input register and the link memory read are
// loaded at acceptance, and the update stage writes the output register when it
// advances. Throughput is set by the single read port of each link memory, read
// at acceptance with write forwarding from the request ahead. Frame ids at or
// above NUM_FRAMES are ignored by pin and unpin. No clearing pass is needed
// after reset.
module lru_victim_selector #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lvs_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lvs_pkg::resp_t out_resp_o
);

  localparam int unsigned Frames   = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;
  localparam int unsigned IdxW     = $clog2(Frames);
  localparam int unsigned MemDepth = 1 << IdxW;

  logic              s1_valid_q;
  lvs_pkg::req_t     s1_req_q;
  logic              out_valid_q;
  lvs_pkg::resp_t    out_resp_q;
  logic              adv, acc;
  lvs_pkg::resp_t    resp;
  lvs_pkg::frame_t   head_nxt;
  lvs_pkg::frame_t   nxt_raddr;
  lvs_pkg::frame_t   nxt_rd, prv_rd;
  lvs_pkg::link_wr_t nxt_wr, prv_wr;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign acc        = in_valid_i && !in_stall_o;

  // a victim request follows the head as it stands after the request ahead
  assign nxt_raddr = (in_req_i.command == lvs_pkg::CMD_VICTIM) ? head_nxt : in_req_i.frame_idx;

  lvs_link_mem #(
    .IdxW     (IdxW),
    .MemDepth (MemDepth)
  ) u_nxt_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (nxt_raddr),
    .wr_i      (nxt_wr),
    .rd_data_o (nxt_rd)
  );

  lvs_link_mem #(
    .IdxW     (IdxW),
    .MemDepth (MemDepth)
  ) u_prv_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (in_req_i.frame_idx),
    .wr_i      (prv_wr),
    .rd_data_o (prv_rd)
  );

  lvs_list_ctrl #(
    .NumFrames (Frames),
    .IdxW      (IdxW),
    .MemDepth  (MemDepth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .req_i      (s1_req_q),
    .nxt_rd_i   (nxt_rd),
    .prv_rd_i   (prv_rd),
    .resp_o     (resp),
    .head_nxt_o (head_nxt),
    .nxt_wr_o   (nxt_wr),
    .prv_wr_o   (prv_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc || (s1_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_req_q <= in_req_i;
    end
    if (adv) begin
      out_resp_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_resp_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_resp_o.list_count <= 7'(Frames)))
    else $error("list count exceeds frame count");

  a_no_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_resp_o.found) |-> (out_resp_o.victim_frame == '0))
    else $error("victim frame set without a found victim");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !in_stall_o) |=> out_valid_q)
    else $error("processed request did not reach the output register");

endmodule

// ----- tb/lru_victim_selector_tb.sv -----
`timescale 1ns / 1ps

module lru_victim_selector_tb;

  localparam int unsigned NumFrames = 64;
  localparam int unsigned IdlePct   = 13;
  localparam int unsigned MaxShown  = 10;
  // command code with no operation behind it
  localparam logic [1:0]  CmdUnused = 2'd3;

  // a backlog entry is either a request or a marker that holds the sender
  // until every outstanding response is back
  typedef struct packed {
    logic          hold;
    lvs_pkg::req_t req;
  } backlog_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  lvs_pkg::req_t  in_req = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  lvs_pkg::resp_t out_resp;

  backlog_t       req_backlog[$];
  lvs_pkg::resp_t resp_due[$];

  logic req_taken = 1'b0;
  logic calm = 1'b0;
  int   cyc = 0;
  int   mismatches = 0;

  // shadow copy of the frame list
  logic            lst_member[NumFrames];
  lvs_pkg::frame_t lst_next[NumFrames];
  lvs_pkg::frame_t lst_prev[NumFrames];
  lvs_pkg::frame_t lst_head;
  lvs_pkg::frame_t lst_tail;
  lvs_pkg::count_t lst_count;

  lru_victim_selector #(
    .NUM_FRAMES(NumFrames)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_resp_o (out_resp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void drop_frame(lvs_pkg::frame_t f);
    lvs_pkg::frame_t p;
    lvs_pkg::frame_t n;
    p = lst_prev[f];
    n = lst_next[f];
    if (lst_count <= 1) begin
      // last one out: head and tail keep their values
    end else if (f == lst_head) begin
      lst_head = n;
    end else if (f == lst_tail) begin
      lst_tail = p;
    end else begin
      lst_next[p] = n;
      lst_prev[n] = p;
    end
    lst_member[f] = 1'b0;
    if (lst_count > 0) lst_count = lst_count - 7'd1;
  endfunction

  function automatic lvs_pkg::resp_t apply_lru_cmd(lvs_pkg::req_t r);
    lvs_pkg::resp_t  rsp;
    lvs_pkg::frame_t f;
    rsp = '0;
    f = r.frame_idx;
    case (r.command)
      lvs_pkg::CMD_VICTIM: begin
        if (lst_count > 0) begin
          rsp.found = 1'b1;
          rsp.victim_frame = lst_head;
          drop_frame(lst_head);
        end
      end
      lvs_pkg::CMD_PIN: begin
        if (lst_member[f]) drop_frame(f);
      end
      lvs_pkg::CMD_UNPIN: begin
        if (!lst_member[f]) begin
          if (lst_count == 0) begin
            lst_head = f;
          end else begin
            lst_next[lst_tail] = f;
            lst_prev[f] = lst_tail;
          end
          lst_tail = f;
          lst_member[f] = 1'b1;
          lst_count = lst_count + 7'd1;
        end
      end
      default: begin
      end
    endcase
    rsp.list_count = lst_count;
    return rsp;
  endfunction

  task automatic push_req(logic [1:0] cmd, int unsigned frame);
    backlog_t b;
    b.hold = 1'b0;
    b.req.command = cmd;
    b.req.frame_idx = lvs_pkg::frame_t'(frame);
    req_backlog.insert(req_backlog.size(), b);
  endtask

  task automatic push_hold();
    backlog_t b;
    b = '0;
    b.hold = 1'b1;
    req_backlog.insert(req_backlog.size(), b);
  endtask

  // monitor: check responses first, then predict the request taken this edge
  always @(posedge clk) begin
    lvs_pkg::resp_t want;
    cyc <= cyc + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (resp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("unexpected response found=%0d victim=%0d count=%0d",
                     out_resp.found, out_resp.victim_frame, out_resp.list_count);
        end else begin
          want = resp_due[0];
          resp_due.delete(0);
          if (out_resp !== want) begin
            mismatches++;
            if (mismatches <= MaxShown)
              $display("mismatch: found %0d/%0d victim %0d/%0d count %0d/%0d (exp/act)",
                       want.found, out_resp.found, want.victim_frame,
                       out_resp.victim_frame, want.list_count, out_resp.list_count);
          end
        end
      end
      if (in_valid && !in_stall) resp_due.insert(resp_due.size(), apply_lru_cmd(in_req));
      req_taken <= in_valid && !in_stall;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= !calm && ($urandom_range(99) < IdlePct);
      if (!(in_valid && !req_taken)) begin
        if (req_backlog.size() != 0 && req_backlog[0].hold) begin
          in_valid <= 1'b0;
          if (resp_due.size() == 0 && !in_valid) req_backlog.delete(0);
        end else if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          in_req <= req_backlog[0].req;
          req_backlog.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned r;
    int unsigned fr;
    int unsigned step;
    int unsigned start;
    logic [1:0]  cmd;

    for (int i = 0; i < NumFrames; i++) lst_member[i] = 1'b0;
    lst_head = '0;
    lst_tail = '0;
    lst_count = '0;

    // directed part
    push_req(lvs_pkg::CMD_VICTIM, 0);       // empty list
    push_req(CmdUnused, 63);                // unused code
    push_req(lvs_pkg::CMD_PIN, 5);          // pin of unlisted frame
    push_req(lvs_pkg::CMD_UNPIN, 0);
    push_req(lvs_pkg::CMD_UNPIN, 63);
    push_req(lvs_pkg::CMD_UNPIN, 0);        // already listed, keeps place
    push_req(lvs_pkg::CMD_UNPIN, 5);
    push_req(lvs_pkg::CMD_UNPIN, 10);
    push_req(lvs_pkg::CMD_UNPIN, 20);
    push_req(lvs_pkg::CMD_PIN, 10);         // middle
    push_req(lvs_pkg::CMD_PIN, 20);         // tail
    push_req(lvs_pkg::CMD_PIN, 0);          // head
    push_req(lvs_pkg::CMD_VICTIM, 42);
    push_req(lvs_pkg::CMD_PIN, 5);          // last one leaves
    push_req(lvs_pkg::CMD_VICTIM, 0);
    push_req(CmdUnused, 0);
    push_req(lvs_pkg::CMD_UNPIN, 42);       // refill after emptied
    push_req(lvs_pkg::CMD_UNPIN, 21);
    push_req(lvs_pkg::CMD_VICTIM, 63);
    push_req(lvs_pkg::CMD_VICTIM, 0);
    push_req(lvs_pkg::CMD_VICTIM, 0);
    push_hold();

    for (int blk = 0; blk < 29; blk++) begin
      mode = (blk % 9 == 4) ? 4 : $urandom_range(3);
      if (mode == 4) begin
        // unpin every frame once, in a scrambled order
        step = 2 * $urandom_range(31) + 1;
        start = $urandom_range(63);
        for (int k = 0; k < NumFrames; k++)
          push_req(lvs_pkg::CMD_UNPIN, (start + k * step) % NumFrames);
      end else begin
        for (int k = 0; k < 50; k++) begin
          r = $urandom_range(99);
          case (mode)
            0: cmd = (r < 70) ? lvs_pkg::CMD_UNPIN : (r < 85) ? lvs_pkg::CMD_PIN :
                     (r < 97) ? lvs_pkg::CMD_VICTIM : CmdUnused;
            1: cmd = (r < 50) ? lvs_pkg::CMD_VICTIM : (r < 75) ? lvs_pkg::CMD_PIN :
                     (r < 97) ? lvs_pkg::CMD_UNPIN : CmdUnused;
            default: cmd = (r < 32) ? lvs_pkg::CMD_VICTIM : (r < 64) ? lvs_pkg::CMD_PIN :
                           (r < 97) ? lvs_pkg::CMD_UNPIN : CmdUnused;
          endcase
          fr = (mode == 3) ? $urandom_range(7) : $urandom_range(63);
          push_req(cmd, fr);
        end
      end
      if (blk % 7 == 6) push_hold();
    end

    // calm stretch with no idling on either side
    wait (cyc >= 700);
    calm = 1'b1;
    wait (cyc >= 1200);
    calm = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (req_backlog.size() != 0 || in_valid || resp_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && resp_due.size() == 0) begin
      $display("lru_victim_selector_tb passed");
    end else begin
      $display("lru_victim_selector_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("lru_victim_selector_tb failed");
    $finish;
  end

endmodule
